/* rtl/was_pkg.sv */
`default_nettype none
package was_pkg;

	localparam int TABLE_ENTRIES = 8;
	localparam int CFG_W = 12;
	localparam int TIME_W = 12;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_NIGHT_WEEK_MASK = 2'd0,
		CFG_NIGHT_ENABLE    = 2'd1,
		CFG_NIGHT_START     = 2'd2,
		CFG_NIGHT_END       = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		op_t        opcode;
		logic [2:0] weekday;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [2:0] entry_index;
		logic [6:0] entry_week_mask;
		logic       entry_enable;
		logic [2:0] entry_action;
		logic [4:0] entry_hour;
		logic [7:0] entry_minute;
		logic       entry_one_shot;
	} cmd_t;

	typedef struct packed {
		logic       night_active;
		logic       any_enabled;
		logic       fired;
		logic [7:0] fired_mask;
		logic [2:0] relay_action;
	} result_t;

	typedef struct packed {
		logic       any_enabled;
		logic [7:0] fired_mask;
		logic [2:0] relay_action;
	} tbl_status_t;

	function automatic logic [TIME_W-1:0] to_minutes(input logic [4:0] h, input logic [7:0] m);
		logic [TIME_W-1:0] hw;
		hw = TIME_W'(h);
		return (hw << 6) - (hw << 2) + TIME_W'(m);
	endfunction

endpackage
`default_nettype wire

/* rtl/was_night.sv */
`default_nettype none
module was_night (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire was_pkg::cfg_idx_t         cfg_index,
	input  wire logic [was_pkg::CFG_W-1:0] cfg_data,
	input  wire logic [was_pkg::TIME_W-1:0] cur,
	output logic                           active
);
	import was_pkg::*;

	logic [6:0]        week_mask_q;
	logic              enable_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			week_mask_q <= '0;
			enable_q    <= 1'b0;
			start_q     <= '0;
			end_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NIGHT_WEEK_MASK: week_mask_q <= cfg_data[6:0];
				CFG_NIGHT_ENABLE:    enable_q    <= cfg_data[0];
				CFG_NIGHT_START:     start_q     <= cfg_data[TIME_W-1:0];
				CFG_NIGHT_END:       end_q       <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (&week_mask_q)
			active = 1'b1;
		else if (!enable_q)
			active = 1'b0;
		else if (start_q < end_q)
			active = (cur >= start_q) && (cur < end_q);
		else
			active = (cur >= start_q) || (cur < end_q);
	end

endmodule
`default_nettype wire

/* rtl/was_table.sv */
`default_nettype none
module was_table (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid,
	input  wire was_pkg::cmd_t              cmd,
	input  wire logic [was_pkg::TIME_W-1:0] cur,
	output was_pkg::tbl_status_t            status
);
	import was_pkg::*;

	localparam int N = TABLE_ENTRIES;

	logic [6:0] mask_q [N];
	logic [2:0] act_q  [N];
	logic [4:0] hr_q   [N];
	logic [7:0] min_q  [N];
	logic [N-1:0] en_q;
	logic [N-1:0] done_q;
	logic [N-1:0] os_q;

	logic [N-1:0] hit, eq, gt, fire, expire;
	logic [N-1:0] en_wr;
	logic         wr_ok;
	logic         any_now;

	assign any_now = |en_q;
	assign wr_ok   = (32'(cmd.entry_index) < N);

	always_comb begin
		for (int i = 0; i < N; i++) begin
			logic [TIME_W-1:0] et;
			et = to_minutes(hr_q[i], min_q[i]);
			hit[i]    = en_q[i] && (cmd.weekday != 3'd0) && mask_q[i][3'(cmd.weekday - 3'd1)];
			eq[i]     = (cur == et);
			gt[i]     = (cur > et);
			fire[i]   = hit[i] && eq[i] && !done_q[i];
			expire[i] = hit[i] && os_q[i] && (fire[i] || gt[i]);
			en_wr[i]  = (wr_ok && (32'(cmd.entry_index) == i)) ? cmd.entry_enable : en_q[i];
		end
	end

	always_comb begin
		status = '0;
		if (cmd.opcode == OP_WRITE) begin
			status.any_enabled = |en_wr;
		end else begin
			status.any_enabled = any_now;
			if (any_now) begin
				for (int i = 0; i < N; i++) begin
					if (fire[i]) begin
						status.fired_mask[i] = 1'b1;
						status.relay_action  = act_q[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				mask_q[i] <= '0;
				act_q[i]  <= '0;
				hr_q[i]   <= '0;
				min_q[i]  <= '0;
			end
			en_q   <= '0;
			done_q <= '0;
			os_q   <= '0;
		end else if (valid) begin
			if (cmd.opcode == OP_WRITE) begin
				if (wr_ok) begin
					for (int i = 0; i < N; i++) begin
						if (32'(cmd.entry_index) == i) begin
							mask_q[i] <= cmd.entry_week_mask;
							en_q[i]   <= cmd.entry_enable;
							act_q[i]  <= cmd.entry_action;
							hr_q[i]   <= cmd.entry_hour;
							min_q[i]  <= cmd.entry_minute;
							os_q[i]   <= cmd.entry_one_shot;
							done_q[i] <= 1'b0;
						end
					end
				end
			end else if (any_now) begin
				for (int i = 0; i < N; i++) begin
					if (hit[i])
						done_q[i] <= eq[i];
					if (expire[i]) begin
						os_q[i]   <= 1'b0;
						mask_q[i] <= '0;
						en_q[i]   <= 1'b0;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/weekly_alarm_scheduler_top.sv */
// Channel   | Ports                              | Transfer
// ----------+------------------------------------+-------------------------------
// command   | start, busy, cmd                   | edge with start high, busy low
// result    | result_valid, result               | one cycle strobe, no hold-off
// config    | cfg_we, cfg_index, cfg_data        | edge with cfg_we high
//
// A command is registered at acceptance; its result is then registered from that stage.
// busy stays low: a command can be taken on every cycle, one result per command.
// The entry table updates as the result is registered, so back-to-back
// commands see each other in order.
// arst_n clears the table, done and one-shot latches and the night registers.
// The receiver cannot stall; results are not held.
`default_nettype none
module weekly_alarm_scheduler_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire was_pkg::cmd_t             cmd,
	output logic                           result_valid,
	output was_pkg::result_t               result,
	input  wire logic                      cfg_we,
	input  wire was_pkg::cfg_idx_t         cfg_index,
	input  wire logic [was_pkg::CFG_W-1:0] cfg_data
);
	import was_pkg::*;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [TIME_W-1:0] cur;
	logic              night;
	tbl_status_t       status;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy)
			cmd_s1 <= cmd;
	end

	assign cur = to_minutes(cmd_s1.hour, {2'b00, cmd_s1.minute});

	was_night u_night (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cur       (cur),
		.active    (night)
	);

	was_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.cmd    (cmd_s1),
		.cur    (cur),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else
			result_valid <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result.night_active <= (cmd_s1.opcode == OP_TICK) && night;
			result.any_enabled  <= status.any_enabled;
			result.fired        <= |status.fired_mask;
			result.fired_mask   <= status.fired_mask;
			result.relay_action <= status.relay_action;
		end
	end

	a_fired_mask: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.fired == (|result.fired_mask)))
		else $error("fired flag disagrees with fired_mask");

	a_action_needs_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.relay_action != 3'd0)) |-> result.fired)
		else $error("relay action without a fired entry");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (cmd_s1.opcode == OP_WRITE)) |=> (!result.fired && !result.night_active))
		else $error("table write produced fire or night flag");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 result_valid)
		else $error("accepted command lost its result");

endmodule
`default_nettype wire

/* tb/sv/alarm_outcome_monitor.sv */
`timescale 1ns / 100ps
module alarm_outcome_monitor (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      busy,
	input  was_pkg::cmd_t                  cmd,
	input  wire logic                      result_valid,
	input  was_pkg::result_t               result,
	input  wire logic                      cfg_we,
	input  was_pkg::cfg_idx_t              cfg_index,
	input  wire logic [was_pkg::CFG_W-1:0] cfg_data,
	output int                             err_count,
	output int                             open_count
);
	import was_pkg::*;

	logic [6:0] day_mask [TABLE_ENTRIES];
	logic       entry_on [TABLE_ENTRIES];
	logic [2:0] entry_act [TABLE_ENTRIES];
	logic [4:0] entry_hr [TABLE_ENTRIES];
	logic [7:0] entry_min [TABLE_ENTRIES];
	logic [7:0] done_bits;
	logic [7:0] once_bits;
	logic [6:0] nt_mask;
	logic       nt_en;
	logic [11:0] nt_start;
	logic [11:0] nt_end;
	result_t    outcome_q [$];

	function automatic logic table_armed();
		logic armed;
		armed = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			armed = armed | entry_on[i];
		return armed;
	endfunction

	function automatic result_t alarm_outcome(input cmd_t c);
		result_t r;
		int cur;
		int et;
		logic hit;
		r = '0;
		if (c.opcode == OP_WRITE) begin
			if (int'(c.entry_index) < TABLE_ENTRIES) begin
				day_mask[c.entry_index] = c.entry_week_mask;
				entry_on[c.entry_index] = c.entry_enable;
				entry_act[c.entry_index] = c.entry_action;
				entry_hr[c.entry_index] = c.entry_hour;
				entry_min[c.entry_index] = c.entry_minute;
				once_bits[c.entry_index] = c.entry_one_shot;
				done_bits[c.entry_index] = 1'b0;
			end
			r.any_enabled = table_armed();
			return r;
		end
		cur = int'(c.hour) * 60 + int'(c.minute);
		if (nt_mask == 7'h7F)
			r.night_active = 1'b1;
		else if (nt_en) begin
			if (nt_start < nt_end)
				r.night_active = (cur >= int'(nt_start)) && (cur < int'(nt_end));
			else
				r.night_active = (cur >= int'(nt_start)) || (cur < int'(nt_end));
		end
		r.any_enabled = table_armed();
		if (r.any_enabled && c.weekday != 3'd0) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (day_mask[i][int'(c.weekday) - 1] && entry_on[i]) begin
					et = int'(entry_hr[i]) * 60 + int'(entry_min[i]);
					if (cur != et)
						done_bits[i] = 1'b0;
					hit = (cur == et) && !done_bits[i];
					if (hit) begin
						done_bits[i] = 1'b1;
						r.fired_mask[i] = 1'b1;
						r.relay_action = entry_act[i];
					end
					// one-shot entries retire once fired or overdue
					if ((hit || cur > et) && once_bits[i]) begin
						once_bits[i] = 1'b0;
						day_mask[i] = '0;
						entry_on[i] = 1'b0;
					end
				end
			end
		end
		r.fired = |r.fired_mask;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				day_mask[i] = '0;
				entry_on[i] = 1'b0;
				entry_act[i] = '0;
				entry_hr[i] = '0;
				entry_min[i] = '0;
			end
			done_bits = '0;
			once_bits = '0;
			nt_mask = '0;
			nt_en = 1'b0;
			nt_start = '0;
			nt_end = '0;
			outcome_q.delete();
			err_count = 0;
			open_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_NIGHT_WEEK_MASK: nt_mask = cfg_data[6:0];
					CFG_NIGHT_ENABLE:    nt_en = cfg_data[0];
					CFG_NIGHT_START:     nt_start = cfg_data;
					CFG_NIGHT_END:       nt_end = cfg_data;
					default: ;
				endcase
			end
			if (result_valid) begin
				if (outcome_q.size() == 0) begin
					$error("result transfer with no command outstanding");
					err_count++;
				end else begin
					want = outcome_q.pop_front();
					check_field("night_active", 8'(want.night_active), 8'(result.night_active));
					check_field("any_enabled", 8'(want.any_enabled), 8'(result.any_enabled));
					check_field("fired", 8'(want.fired), 8'(result.fired));
					check_field("fired_mask", want.fired_mask, result.fired_mask);
					check_field("relay_action", 8'(want.relay_action), 8'(result.relay_action));
				end
			end
			if (start && !busy)
				outcome_q.push_back(alarm_outcome(cmd));
			open_count = outcome_q.size();
		end
	end

endmodule

/* tb/sv/weekly_alarm_scheduler_top_test.sv */
`timescale 1ns / 100ps
module weekly_alarm_scheduler_top_test;
	import was_pkg::*;

	localparam int IDLE_LIMIT = 500;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 195;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	cmd_t             cmd = '0;
	logic             result_valid;
	result_t          result;
	logic             cfg_we = 1'b0;
	cfg_idx_t         cfg_index = CFG_NIGHT_WEEK_MASK;
	logic [CFG_W-1:0] cfg_data = '0;
	int               err_count;
	int               open_count;
	int               idle_cycles = 0;
	logic [6:0]       aim_days [TABLE_ENTRIES];
	int               aim_time [TABLE_ENTRIES];
	cmd_t             last_tick = '0;

	always #4 clk = ~clk;

	weekly_alarm_scheduler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	alarm_outcome_monitor outcome_mon (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.err_count(err_count),
		.open_count(open_count)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || cfg_we)
				idle_cycles <= 0;
			else if (idle_cycles == IDLE_LIMIT) begin
				$display("weekly_alarm_scheduler_top_test: done, errors");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic cmd_t noise_cmd();
		cmd_t c;
		c.opcode = $urandom_range(0, 1) ? OP_WRITE : OP_TICK;
		c.weekday = 3'($urandom);
		c.hour = 5'($urandom);
		c.minute = 6'($urandom);
		c.entry_index = 3'($urandom);
		c.entry_week_mask = 7'($urandom);
		c.entry_enable = 1'($urandom);
		c.entry_action = 3'($urandom);
		c.entry_hour = 5'($urandom);
		c.entry_minute = 8'($urandom);
		c.entry_one_shot = 1'($urandom);
		return c;
	endfunction

	// fold times past 31:59 into minutes above 59
	function automatic cmd_t tick_at(input int d, input int t);
		cmd_t c;
		int h;
		c = noise_cmd();
		c.opcode = OP_TICK;
		c.weekday = 3'(d);
		h = t / 60;
		if (h > 31)
			h = 31;
		c.hour = 5'(h);
		c.minute = 6'(t - h * 60);
		return c;
	endfunction

	function automatic cmd_t entry_write(input int idx, input logic [6:0] days, input logic en,
			input logic [2:0] act, input logic [4:0] h, input logic [7:0] m, input logic once);
		cmd_t c;
		c = noise_cmd();
		c.opcode = OP_WRITE;
		c.entry_index = 3'(idx);
		c.entry_week_mask = days;
		c.entry_enable = en;
		c.entry_action = act;
		c.entry_hour = h;
		c.entry_minute = m;
		c.entry_one_shot = once;
		return c;
	endfunction

	function automatic cmd_t pick_item();
		cmd_t c;
		int k;
		int s;
		int d;
		int t;
		k = $urandom_range(0, 99);
		s = $urandom_range(0, TABLE_ENTRIES - 1);
		if (k < 22) begin
			c = noise_cmd();
			c.opcode = OP_WRITE;
			if ($urandom_range(0, 3) != 0) begin
				c.entry_enable = 1'b1;
				if (c.entry_week_mask == '0)
					c.entry_week_mask = 7'h7F;
				// cluster times so several entries share a minute
				if ($urandom_range(0, 2) != 0) begin
					c.entry_hour = 5'($urandom_range(7, 8));
					c.entry_minute = 8'($urandom_range(0, 3));
				end
			end
		end else if (k < 72) begin
			d = $urandom_range(1, 7);
			if (aim_days[s] != '0)
				while (!aim_days[s][d - 1])
					d = (d % 7) + 1;
			t = aim_time[s];
			case ($urandom_range(0, 5))
				0: t = t + 1;
				1: t = t - 1;
				2: t = t + $urandom_range(2, 300);
				default: ;
			endcase
			if (t < 0 || t > 1923)
				t = $urandom_range(0, 1923);
			c = tick_at(d, t);
		end else if (k < 84)
			c = last_tick;
		else if (k < 94)
			c = tick_at($urandom_range(0, 7), $urandom_range(0, 1923));
		else
			c = noise_cmd();
		return c;
	endfunction

	task automatic issue(input cmd_t c);
		logic took;
		start <= 1'b1;
		cmd <= c;
		if (c.opcode == OP_WRITE) begin
			aim_days[c.entry_index] = c.entry_enable ? c.entry_week_mask : 7'h00;
			aim_time[c.entry_index] = int'(c.entry_hour) * 60 + int'(c.entry_minute);
		end else
			last_tick = c;
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic pause(input int n);
		start <= 1'b0;
		cmd <= noise_cmd();
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		pause(1);
		do @(negedge clk); while (open_count != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_night(input logic [6:0] mask, input logic en,
			input logic [11:0] s, input logic [11:0] e);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_NIGHT_WEEK_MASK;
		cfg_data <= CFG_W'(mask);
		@(posedge clk);
		cfg_index <= CFG_NIGHT_ENABLE;
		cfg_data <= CFG_W'(en);
		@(posedge clk);
		cfg_index <= CFG_NIGHT_START;
		cfg_data <= s;
		@(posedge clk);
		cfg_index <= CFG_NIGHT_END;
		cfg_data <= e;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int burst;
		int sent;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			aim_days[i] = '0;
			aim_time[i] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		program_night(7'h7F, 1'b0, 12'd0, 12'd0);
		issue(tick_at(0, 1923));
		issue(tick_at(7, 0));
		issue(entry_write(0, 7'h7F, 1'b1, 3'd7, 5'd31, 8'd255, 1'b0));
		issue(entry_write(7, 7'h01, 1'b1, 3'd5, 5'd0, 8'd0, 1'b1));
		issue(tick_at(1, 0));
		issue(entry_write(3, 7'h04, 1'b1, 3'd3, 5'd10, 8'd30, 1'b0));
		issue(tick_at(3, 630));
		issue(tick_at(3, 630));
		issue(tick_at(3, 631));
		issue(tick_at(3, 630));
		issue(entry_write(4, 7'h04, 1'b1, 3'd6, 5'd10, 8'd30, 1'b0));
		issue(tick_at(3, 631));
		issue(tick_at(3, 630));
		issue(entry_write(5, 7'h40, 1'b1, 3'd1, 5'd1, 8'd0, 1'b1));
		issue(tick_at(7, 120));
		issue(entry_write(2, 7'h02, 1'b1, 3'd2, 5'd0, 8'd200, 1'b0));
		issue(tick_at(2, 200));
		issue(tick_at(0, 200));
		issue(entry_write(6, 7'h7F, 1'b0, 3'd4, 5'd3, 8'd20, 1'b1));
		issue(tick_at(2, 200));
		issue(entry_write(1, 7'h00, 1'b0, 3'd0, 5'd0, 8'd0, 1'b0));
		issue(tick_at(7, 1923));

		for (int p = 1; p <= PHASES; p++) begin
			case (p)
				1: program_night(7'h00, 1'b0, 12'd0, 12'd0);
				2: program_night(7'h00, 1'b1, 12'd360, 12'd1080);
				3: program_night(7'h55, 1'b1, 12'd1320, 12'd420);
				4: program_night(7'h7E, 1'b1, 12'd600, 12'd600);
				5: program_night(7'h00, 1'b1, 12'd0, 12'hFFF);
				6: program_night(7'h7F, 1'b1, 12'hFFF, 12'd0);
				default: program_night(7'($urandom), 1'($urandom),
					$urandom_range(0, 1) ? 12'($urandom_range(0, 1923)) : 12'($urandom),
					$urandom_range(0, 1) ? 12'($urandom_range(0, 1923)) : 12'($urandom));
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
				for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
					issue(pick_item());
					sent++;
				end
				if ($urandom_range(0, 9) == 0)
					drain();
				else if ($urandom_range(0, 2) != 0)
					pause($urandom_range(1, 12));
			end
		end

		drain();
		if (err_count == 0)
			$display("weekly_alarm_scheduler_top_test: done, clean");
		else
			$display("weekly_alarm_scheduler_top_test: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
rtl/was_pkg.sv
rtl/was_night.sv
rtl/was_table.sv
rtl/weekly_alarm_scheduler_top.sv
tb/sv/alarm_outcome_monitor.sv
tb/sv/weekly_alarm_scheduler_top_test.sv
